// ===== hw/rtl/wpm_pkg.sv =====
`default_nettype none
package wpm_pkg;

    localparam int PAT_MAX     = 64;
    localparam int ROW_W       = PAT_MAX + 1;
    localparam int LEN_W       = $clog2(PAT_MAX + 1);
    localparam int IDX_W       = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYM_STAR = 8'd42;
    localparam logic [7:0] SYM_ANY  = 8'd63;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEXT   = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_TEXT,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } in_word_t;

    typedef struct packed {
        logic match;
        logic rejected;
    } out_word_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] symbol;
        logic       is_star;
        logic       is_any;
    } q_item_t;

    typedef struct packed {
        logic    push;
        q_item_t item;
    } q_wr_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_rd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wpm_front.sv =====
`default_nettype none
module wpm_front
    import wpm_pkg::*;
(
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire in_word_t item,
    input  wire logic     q_full,
    output q_wr_t         q_wr
);

    op_t op;

    always_comb
    begin
        unique case (item.mode)
            MODE_CLEAR:  op = OP_CLEAR;
            MODE_APPEND: op = OP_APPEND;
            MODE_TEXT:   op = OP_TEXT;
            default:     op = OP_NOP;
        endcase
    end

    assign item_stall           = q_full;
    assign q_wr.push            = item_valid && !q_full;
    assign q_wr.item.op         = op;
    assign q_wr.item.symbol     = item.symbol;
    assign q_wr.item.is_star    = (item.symbol == SYM_STAR);
    assign q_wr.item.is_any     = (item.symbol == SYM_ANY);

endmodule
`default_nettype wire

// ===== hw/rtl/wpm_queue.sv =====
`default_nettype none
module wpm_queue
    import wpm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire q_wr_t q_wr,
    output logic       q_full,
    input  wire logic  q_pop,
    output q_rd_t      q_rd
);

    q_item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;

    assign q_full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_rd.valid   = (count_reg != '0);
    assign q_rd.item    = entry_reg[rd_ptr_reg];
    assign do_pop       = q_pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = q_wr.push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push && !do_pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (!q_wr.push && do_pop)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wpm_back.sv =====
`default_nettype none
module wpm_back
    import wpm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire q_rd_t q_rd,
    output logic       q_pop,
    output logic       result_valid,
    input  wire logic  result_stall,
    output out_word_t  result
);

    logic [7:0]       sym_reg  [PAT_MAX];
    logic             star_reg [PAT_MAX];
    logic             any_reg  [PAT_MAX];

    logic [LEN_W-1:0] len_reg, len_next, len_inc;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             text_reg, text_next;
    logic             allstar_reg, allstar_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_reg, out_next;

    logic [ROW_W-1:0] gen, prop, add_a, add_b, add_s, carry, text_row;
    logic             do_write;

    assign q_pop   = q_rd.valid && (!out_valid_reg || !result_stall);
    assign len_inc = LEN_W'(len_reg + 1'b1);

    always_comb
    begin
        gen     = '0;
        prop    = '0;
        for (int j = 1; j <= PAT_MAX; j++)
        begin
            if (LEN_W'(j) <= len_reg)
            begin
                prop[j] = star_reg[j-1];
                if (star_reg[j-1])
                begin
                    gen[j] = row_reg[j];
                end
                else
                begin
                    gen[j] = row_reg[j-1] && (any_reg[j-1] || (sym_reg[j-1] == q_rd.item.symbol));
                end
            end
        end
        add_a    = gen | prop;
        add_b    = gen;
        add_s    = ROW_W'(add_a + add_b);
        carry    = add_s ^ add_a ^ add_b;
        text_row = gen | (prop & carry);
    end

    always_comb
    begin
        len_next          = len_reg;
        row_next          = row_reg;
        text_next         = text_reg;
        allstar_next      = allstar_reg;
        do_write          = 1'b0;
        out_next.rejected = 1'b0;
        unique case (q_rd.item.op)
            OP_CLEAR:
            begin
                len_next     = '0;
                row_next     = ROW_W'(1);
                text_next    = 1'b0;
                allstar_next = 1'b1;
            end
            OP_APPEND:
            begin
                if (text_reg || (len_reg >= LEN_W'(PAT_MAX)))
                begin
                    out_next.rejected = 1'b1;
                end
                else
                begin
                    do_write          = 1'b1;
                    allstar_next      = allstar_reg && q_rd.item.is_star;
                    len_next          = len_inc;
                    row_next[len_inc] = allstar_next;
                end
            end
            OP_TEXT:
            begin
                text_next = 1'b1;
                row_next  = text_row;
            end
            default:
            begin
            end
        endcase
        out_next.match = row_next[len_next];
        out_valid_next = q_pop ? 1'b1 : (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            row_reg       <= ROW_W'(1);
            text_reg      <= 1'b0;
            allstar_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                len_reg     <= len_next;
                row_reg     <= row_next;
                text_reg    <= text_next;
                allstar_reg <= allstar_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
        if (q_pop && do_write)
        begin
            sym_reg[len_reg[IDX_W-1:0]]  <= q_rd.item.symbol;
            star_reg[len_reg[IDX_W-1:0]] <= q_rd.item.is_star;
            any_reg[len_reg[IDX_W-1:0]]  <= q_rd.item.is_any;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/wildcard_pattern_match_core.sv =====
`default_nettype none
// Streaming wildcard matcher: clear, append pattern bytes ('*' any run, '?' any one byte),
// then stream text bytes; every word returns one result word with match (text so far
// matches the whole pattern) and rejected (pattern byte dropped because the store is full
// or text has started). One word per cycle is sustained while result_stall is low: the front
// decodes into a four-entry queue, and the back updates all pattern positions of the match
// row at once through a row-wide carry chain that carries star runs, then holds the result
// in an output register that drives result_valid.
module wildcard_pattern_match_core
    import wpm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire in_word_t item,
    output logic          result_valid,
    input  wire logic     result_stall,
    output out_word_t     result
);

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    wpm_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_wr       (q_wr)
    );

    wpm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rd   (q_rd)
    );

    wpm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rd         (q_rd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> result_valid)
        else $error("popped word produced no result");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_rd.item.op == OP_CLEAR)) |=> (result.match && !result.rejected))
        else $error("clear word did not report an empty match");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (item_stall && !q_pop) |=> item_stall)
        else $error("queue left full state without a pop");
`endif

endmodule
`default_nettype wire
